// ===== rtl/nrt_pkg.sv =====
// Shared constants for the name registry table: field widths, operation and status codes,
// and default sizes. Used by the top module and nrt_ctrl; depends on nothing.
package nrt_pkg;

   localparam int ENTRIES_DEF    = 128;
   localparam int NAME_BYTES_DEF = 16;

   localparam int OP_W     = 2;
   localparam int NAME_W   = 64;
   localparam int PORT_W   = 16;
   localparam int OWNER_W  = 16;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND       = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OWNER    = 3'd4;

endpackage

// ===== rtl/name_registry_table_unit.sv =====
// Name registry table: binds zero-padded names to port ids and owner tasks.
// Each transaction scans every slot through the table memory's single read port, one slot a cycle.
// One request at a time: a new one is taken only once the last has loaded its reply, even while that reply waits.
// After reset a clearing pass writes every slot empty; requests wait until it ends.
// Depends on nrt_pkg, nrt_mem and nrt_ctrl.
module name_registry_table_unit #(
   parameter int ENTRIES    = nrt_pkg::ENTRIES_DEF,
   parameter int NAME_BYTES = nrt_pkg::NAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nrt_pkg::OP_W-1:0]      req_op,
   input  logic [nrt_pkg::NAME_W-1:0]    req_name_hi,
   input  logic [nrt_pkg::NAME_W-1:0]    req_name_lo,
   input  logic [nrt_pkg::PORT_W-1:0]    req_port_id,
   input  logic [nrt_pkg::OWNER_W-1:0]   req_owner_task,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nrt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [nrt_pkg::PORT_W-1:0]    rsp_found_port
);

   localparam int ENT_W = 8 * NAME_BYTES + nrt_pkg::PORT_W + nrt_pkg::OWNER_W;
   localparam int IDX_W = $clog2(ENTRIES);

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [ENT_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [ENT_W-1:0] mem_rd_data;

   nrt_mem #(
      .ENTRIES (ENTRIES),
      .ENT_W   (ENT_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   nrt_ctrl #(
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES),
      .ENT_W      (ENT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_name_hi    (req_name_hi),
      .req_name_lo    (req_name_lo),
      .req_port_id    (req_port_id),
      .req_owner_task (req_owner_task),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found_port (rsp_found_port),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

endmodule

// ===== rtl/nrt_mem.sv =====
// Table storage: one synchronous memory holding key, port and owner for every slot,
// one write port and one read port with a registered read. Depends on nothing.
module nrt_mem #(
   parameter int ENTRIES = 128,
   parameter int ENT_W   = 160
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [ENT_W-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [ENT_W-1:0]           rd_data_ff
);

   logic [ENT_W-1:0] store_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/nrt_ctrl.sv =====
// Request sequencer: clears the table after reset, scans every slot for a match and the
// lowest free slot, then writes the slot where the operation calls for it and loads the reply register. Uses nrt_pkg.
module nrt_ctrl #(
   parameter int ENTRIES    = 128,
   parameter int NAME_BYTES = 16,
   parameter int ENT_W      = 8 * NAME_BYTES + nrt_pkg::PORT_W + nrt_pkg::OWNER_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nrt_pkg::OP_W-1:0]            req_op,
   input  logic [nrt_pkg::NAME_W-1:0]          req_name_hi,
   input  logic [nrt_pkg::NAME_W-1:0]          req_name_lo,
   input  logic [nrt_pkg::PORT_W-1:0]          req_port_id,
   input  logic [nrt_pkg::OWNER_W-1:0]         req_owner_task,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nrt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [nrt_pkg::PORT_W-1:0]          rsp_found_port,
   output logic                                mem_wr_en,
   output logic [$clog2(ENTRIES)-1:0]          mem_wr_addr,
   output logic [ENT_W-1:0]                    mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(ENTRIES)-1:0]          mem_rd_addr,
   input  logic [ENT_W-1:0]                    mem_rd_data
);

   localparam int KEY_W = 8 * NAME_BYTES;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [nrt_pkg::OP_W-1:0]      op_ff, op_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic [nrt_pkg::PORT_W-1:0]    port_ff, port_in;
   logic [nrt_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic                          hit_ff, hit_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic [nrt_pkg::PORT_W-1:0]    hit_port_ff, hit_port_in;
   logic [nrt_pkg::OWNER_W-1:0]   hit_owner_ff, hit_owner_in;
   logic                          free_ff, free_in;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [nrt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [nrt_pkg::PORT_W-1:0]    rsp_port_ff, rsp_port_in;

   logic [2*nrt_pkg::NAME_W-1:0]  name_cat;
   logic [KEY_W-1:0]              rd_key;
   logic [nrt_pkg::PORT_W-1:0]    rd_port;
   logic                          rd_used;
   logic                          out_free;
   logic [nrt_pkg::STATUS_W-1:0]  dec_status;
   logic [nrt_pkg::PORT_W-1:0]    dec_port;
   logic                          dec_wr;
   logic [IDX_W-1:0]              dec_addr;
   logic [ENT_W-1:0]              dec_data;

   // Name bytes beyond the configured length fall away when the key is taken from this, before any compare or store.
   assign name_cat = {req_name_hi, req_name_lo};
   assign rd_key   = mem_rd_data[ENT_W-1 -: KEY_W];
   assign rd_port  = mem_rd_data[nrt_pkg::OWNER_W +: nrt_pkg::PORT_W];
   assign rd_used  = (rd_port != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_port = rsp_port_ff;

   // Outcome of a finished scan.
   always_comb begin
      dec_status = nrt_pkg::ST_NOTFOUND;
      dec_port   = '0;
      dec_wr     = 1'b0;
      dec_addr   = hit_idx_ff;
      dec_data   = '0;
      case (op_ff)
         nrt_pkg::OP_REGISTER: begin
            if (hit_ff) begin
               dec_status = nrt_pkg::ST_DUP;
            end else if (free_ff) begin
               dec_status = nrt_pkg::ST_OK;
               dec_wr     = (port_ff != '0);
               dec_addr   = free_idx_ff;
               dec_data   = {key_ff, port_ff, owner_ff};
            end else begin
               dec_status = nrt_pkg::ST_FULL;
            end
         end
         nrt_pkg::OP_UNREGISTER: begin
            if (hit_ff) begin
               dec_port = hit_port_ff;
               if (hit_owner_ff == owner_ff) begin
                  dec_status = nrt_pkg::ST_OK;
                  dec_wr     = 1'b1;
               end else begin
                  dec_status = nrt_pkg::ST_OWNER;
               end
            end
         end
         nrt_pkg::OP_FIND: begin
            if (hit_ff) begin
               dec_status = nrt_pkg::ST_OK;
               dec_port   = hit_port_ff;
            end
         end
         default: begin
            dec_status = nrt_pkg::ST_NOTFOUND;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      port_in       = port_ff;
      owner_in      = owner_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_port_in   = hit_port_ff;
      hit_owner_in  = hit_owner_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = issue_ff[IDX_W-1:0];
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_ff[IDX_W-1:0];

      // Check the slot whose data came back this cycle; the first hit and first free win.
      if (chk_valid_ff) begin
         if (rd_used && rd_key == key_ff && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_port_in  = rd_port;
            hit_owner_in = mem_rd_data[nrt_pkg::OWNER_W-1:0];
         end
         if (!rd_used && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            issue_in  = issue_ff + 1'b1;
            if (issue_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = name_cat[2*nrt_pkg::NAME_W-1 -: KEY_W];
               port_in  = req_port_id;
               owner_in = req_owner_task;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               issue_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < CNT_W'(ENTRIES)) begin
               mem_rd_en    = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[IDX_W-1:0];
               issue_in     = issue_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               mem_wr_en     = dec_wr;
               mem_wr_addr   = dec_addr;
               mem_wr_data   = dec_data;
               rsp_valid_in  = 1'b1;
               rsp_status_in = dec_status;
               rsp_port_in   = dec_port;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      port_ff       <= port_in;
      owner_ff      <= owner_in;
      hit_idx_ff    <= hit_idx_in;
      hit_port_ff   <= hit_port_in;
      hit_owner_ff  <= hit_owner_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
   end

endmodule
